### rtl/tfc_pkg.sv
// package: payload types, command codes and stack control types for the track flow unit
`default_nettype none
package tfc_pkg;

	localparam int PosW = 16;
	localparam int CntW = 8;
	localparam int FuncW = 3;

	localparam logic [FuncW-1:0] FUNC_JUMP   = 3'd0;
	localparam logic [FuncW-1:0] FUNC_CALL   = 3'd1;
	localparam logic [FuncW-1:0] FUNC_RETURN = 3'd2;
	localparam logic [FuncW-1:0] FUNC_COND   = 3'd3;
	localparam logic [FuncW-1:0] FUNC_REPEAT = 3'd4;
	localparam logic [FuncW-1:0] FUNC_LOOP   = 3'd5;

	typedef struct packed {
		logic [FuncW-1:0] func;
		logic [PosW-1:0]  target_address;
		logic [PosW-1:0]  after_position;
		logic [CntW-1:0]  loop_count;
	} tfc_cmd_t;

	typedef struct packed {
		logic [PosW-1:0] next_position;
		logic            stop_track;
	} tfc_res_t;

	// counted stack entry: return position and remaining count
	typedef struct packed {
		logic [PosW-1:0] pos;
		logic [CntW-1:0] cnt;
	} tfc_entry_t;

	typedef enum logic [1:0] {
		STK_HOLD,
		STK_PUSH,
		STK_POP,
		STK_WRITE
	} stk_op_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic nearly_full;
	} stk_stat_t;

endpackage
`default_nettype wire

### rtl/track_flow_control_stacks.sv
// top level: flow command decode, three cell-chain stacks, conditional flag, result register
//
//  channel | direction | beat payload                                         | handshake
//  cmd     | in        | func, target_address, after_position, loop_count     | cmd_valid / cmd_stall
//  res     | out       | next_position, stop_track                            | res_valid / res_stall
//  cfg     | in        | force_conditional                                    | cfg_we
//
// one command per cycle while cmd_stall is low; its result appears in the output register on the next cycle
// the stack tops are compared and pushed or popped in the same cycle the command is taken
// reset clears the three depths, the conditional flag and the output valid
// cmd_stall rises only while a finished result waits under res_stall
`default_nettype none
module track_flow_control_stacks #(
	parameter int CALL_DEPTH   = 8,
	parameter int REPEAT_DEPTH = 8,
	parameter int LOOP_DEPTH   = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_stall,
	input  tfc_pkg::tfc_cmd_t  cmd,
	output logic               res_valid,
	input  wire                res_stall,
	output tfc_pkg::tfc_res_t  res,
	input  wire                cfg_we,
	input  wire logic          cfg_wdata
);
	import tfc_pkg::*;

	localparam int EntW = $bits(tfc_entry_t);

	logic       accept;
	logic       force_q;
	logic       armed_q;
	logic       res_valid_q;
	tfc_res_t   res_q;
	tfc_res_t   res_d;
	logic       armed_d;

	stk_op_t    call_op, rep_op, loop_op;
	logic [PosW-1:0] call_top;
	tfc_entry_t rep_din, rep_top, loop_din, loop_top;
	stk_stat_t  call_stat, rep_stat, loop_stat;

	logic       call_match, rep_match, loop_match;
	logic [CntW-1:0] rep_dec, loop_dec;

	assign cmd_stall = res_valid_q && res_stall;
	assign accept    = cmd_valid && !cmd_stall;

	assign call_match = !call_stat.empty && (call_top == cmd.after_position);
	assign rep_match  = !rep_stat.empty && (rep_top.pos == cmd.after_position);
	assign loop_match = !loop_stat.empty && (loop_top.pos == cmd.after_position);
	assign rep_dec    = rep_top.cnt - CntW'(1);
	assign loop_dec   = loop_top.cnt - CntW'(1);

	always_comb begin
		call_op            = STK_HOLD;
		rep_op             = STK_HOLD;
		loop_op            = STK_HOLD;
		rep_din.pos        = cmd.after_position;
		rep_din.cnt        = cmd.loop_count;
		loop_din.pos       = cmd.after_position;
		loop_din.cnt       = cmd.loop_count;
		armed_d            = armed_q;
		res_d.next_position = cmd.after_position;
		res_d.stop_track   = 1'b0;
		unique case (cmd.func)
			FUNC_JUMP: begin
				res_d.next_position = cmd.target_address;
			end
			FUNC_CALL: begin
				res_d.next_position = cmd.target_address;
				if (!call_match) begin
					if (!call_stat.full)
						call_op = STK_PUSH;
					res_d.stop_track = call_stat.nearly_full;
				end
			end
			FUNC_RETURN: begin
				if (call_stat.empty) begin
					res_d.stop_track = 1'b1;
				end else begin
					call_op = STK_POP;
					res_d.next_position = call_top;
				end
			end
			FUNC_COND: begin
				armed_d = 1'b1;
				if (armed_q || force_q)
					res_d.next_position = cmd.target_address;
			end
			FUNC_REPEAT: begin
				if (rep_match) begin
					if (rep_dec != '0) begin
						rep_op = STK_WRITE;
						rep_din.pos = rep_top.pos;
						rep_din.cnt = rep_dec;
						res_d.next_position = cmd.target_address;
					end else begin
						rep_op = STK_POP;
					end
				end else begin
					if (!rep_stat.full)
						rep_op = STK_PUSH;
					res_d.stop_track = rep_stat.nearly_full;
					res_d.next_position = cmd.target_address;
				end
			end
			FUNC_LOOP: begin
				if (loop_match) begin
					if (loop_dec == '0) begin
						loop_op = STK_POP;
						res_d.next_position = cmd.target_address;
					end else begin
						loop_op = STK_WRITE;
						loop_din.pos = loop_top.pos;
						loop_din.cnt = loop_dec;
					end
				end else begin
					if (!loop_stat.full)
						loop_op = STK_PUSH;
					res_d.stop_track = loop_stat.nearly_full;
				end
			end
			default: ;
		endcase
		// nothing moves unless a beat is taken
		if (!accept) begin
			call_op = STK_HOLD;
			rep_op  = STK_HOLD;
			loop_op = STK_HOLD;
			armed_d = armed_q;
		end
	end

	tfc_stack #(.W(PosW), .DEPTH(CALL_DEPTH)) u_call_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (call_op),
		.din    (cmd.after_position),
		.top    (call_top),
		.stat   (call_stat)
	);

	tfc_stack #(.W(EntW), .DEPTH(REPEAT_DEPTH)) u_repeat_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (rep_op),
		.din    (rep_din),
		.top    (rep_top),
		.stat   (rep_stat)
	);

	tfc_stack #(.W(EntW), .DEPTH(LOOP_DEPTH)) u_loop_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (loop_op),
		.din    (loop_din),
		.top    (loop_top),
		.stat   (loop_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_q     <= 1'b0;
			armed_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				force_q <= cfg_wdata;
			armed_q <= armed_d;
			if (accept)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_empty_return_stops: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.func == FUNC_RETURN && call_stat.empty |=> res_valid && res.stop_track)
		else $error("return on empty call stack did not stop the track");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid)
		else $error("command stalled with no result pending");

	a_armed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |=> armed_q)
		else $error("conditional flag cleared without reset");

	a_full_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		call_stat.full && call_op == STK_PUSH |-> 1'b0)
		else $error("push issued onto a full call stack");

endmodule
`default_nettype wire

### rtl/tfc_cell.sv
// one stack cell: holds an entry and trades it with its neighbors on push and pop
`default_nettype none
module tfc_cell #(
	parameter int W = 16
) (
	input  wire                   clk,
	input  tfc_pkg::stk_op_t      op,
	input  wire logic [W-1:0]     from_up,
	input  wire logic [W-1:0]     from_down,
	output logic      [W-1:0]     value
);
	import tfc_pkg::*;

	logic [W-1:0] value_q;

	always_ff @(posedge clk) begin
		unique case (op)
			STK_PUSH:  value_q <= from_up;
			STK_POP:   value_q <= from_down;
			STK_WRITE: value_q <= from_up;
			STK_HOLD:  value_q <= value_q;
			default:   value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule
`default_nettype wire

### rtl/tfc_stack.sv
// stack built as a chain of cells, top entry in cell zero, with its depth counter
`default_nettype none
module tfc_stack #(
	parameter int W     = 16,
	parameter int DEPTH = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  tfc_pkg::stk_op_t      op,
	input  wire logic [W-1:0]     din,
	output logic      [W-1:0]     top,
	output tfc_pkg::stk_stat_t    stat
);
	import tfc_pkg::*;

	localparam int DW = $clog2(DEPTH + 1);

	logic [W-1:0] cell_val [DEPTH];
	logic [DW-1:0] depth_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		stk_op_t      cell_op;
		logic [W-1:0] up_val;
		logic [W-1:0] down_val;

		// only the top cell takes an in-place write
		assign cell_op  = (i == 0 || op != STK_WRITE) ? op : STK_HOLD;
		assign up_val   = (i == 0) ? din : cell_val[(i == 0) ? 0 : i - 1];
		assign down_val = (i == DEPTH - 1) ? cell_val[i] : cell_val[(i == DEPTH - 1) ? i : i + 1];

		tfc_cell #(.W(W)) u_cell (
			.clk       (clk),
			.op        (cell_op),
			.from_up   (up_val),
			.from_down (down_val),
			.value     (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else begin
			unique case (op)
				STK_PUSH: depth_q <= depth_q + DW'(1);
				STK_POP:  depth_q <= depth_q - DW'(1);
				default:  depth_q <= depth_q;
			endcase
		end
	end

	assign top              = cell_val[0];
	assign stat.empty       = (depth_q == '0);
	assign stat.full        = (depth_q == DW'(DEPTH));
	assign stat.nearly_full = (depth_q >= DW'(DEPTH - 1));

endmodule
`default_nettype wire

### tb/tb.sv
// testbench for the track flow-control unit: directed table, shaped random phases, scoreboard
`default_nettype none
module tb;
	import tfc_pkg::*;

	localparam int CALL_DEPTH   = 8;
	localparam int REPEAT_DEPTH = 8;
	localparam int LOOP_DEPTH   = 8;
	localparam int PHASE_ITEMS  = 240;
	localparam int NUM_PHASES   = 5;
	localparam int HOLD_LEN     = 60;
	localparam int SETTLE       = 3;
	localparam int CYCLE_LIMIT  = 200000;

	localparam logic [FuncW-1:0] FUNC_RSVD_LO = 3'd6;
	localparam logic [FuncW-1:0] FUNC_RSVD_HI = 3'd7;

	typedef struct {
		tfc_cmd_t c;
		bit       fixed;
		tfc_res_t r;
	} step_row_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     cmd_valid = 1'b0;
	tfc_cmd_t cmd       = '0;
	logic     res_stall = 1'b0;
	logic     cfg_we    = 1'b0;
	logic     cfg_wdata = 1'b0;
	logic     cmd_stall;
	logic     res_valid;
	tfc_res_t res;

	// predictor state
	logic [PosW-1:0] call_stk [CALL_DEPTH];
	logic [PosW-1:0] rep_stk  [REPEAT_DEPTH];
	logic [CntW-1:0] rep_cnt  [REPEAT_DEPTH];
	logic [PosW-1:0] loop_stk [LOOP_DEPTH];
	logic [CntW-1:0] loop_cnt [LOOP_DEPTH];
	int   call_dep   = 0;
	int   rep_dep    = 0;
	int   loop_dep   = 0;
	bit   cond_armed = 1'b0;
	bit   force_cond = 1'b0;

	tfc_res_t  pending_res[$];
	step_row_t directed[$];

	int fail_cnt    = 0;
	int n_items     = 0;
	int n_checked   = 0;
	int n_stops     = 0;
	int cycle_cnt   = 0;
	int stall_pct   = 0;
	int sender_pct  = 0;
	int hold_req    = 0;
	int hold_seen   = 0;
	int hold_left   = 0;

	track_flow_control_stacks #(
		.CALL_DEPTH  (CALL_DEPTH),
		.REPEAT_DEPTH(REPEAT_DEPTH),
		.LOOP_DEPTH  (LOOP_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// next position and stop flag for one command; updates the stacks
	function automatic tfc_res_t flow_step(input tfc_cmd_t c);
		tfc_res_t r;
		r.next_position = c.after_position;
		r.stop_track = 1'b0;
		case (c.func)
			FUNC_JUMP: r.next_position = c.target_address;
			FUNC_CALL: begin
				r.next_position = c.target_address;
				// same call site again: nothing pushed
				if (!(call_dep > 0 && call_stk[call_dep-1] == c.after_position)) begin
					if (call_dep < CALL_DEPTH) begin
						call_stk[call_dep] = c.after_position;
						call_dep++;
					end
					r.stop_track = (call_dep >= CALL_DEPTH);
				end
			end
			FUNC_RETURN: begin
				if (call_dep > 0) begin
					call_dep--;
					r.next_position = call_stk[call_dep];
				end else begin
					r.stop_track = 1'b1;
				end
			end
			FUNC_COND: begin
				if (force_cond)
					cond_armed = 1'b1;
				if (!cond_armed)
					cond_armed = 1'b1;
				else
					r.next_position = c.target_address;
			end
			FUNC_REPEAT: begin
				if (rep_dep > 0 && rep_stk[rep_dep-1] == c.after_position) begin
					rep_cnt[rep_dep-1] = rep_cnt[rep_dep-1] - 8'd1;
					if (rep_cnt[rep_dep-1] != 0)
						r.next_position = c.target_address;
					else
						rep_dep--;
				end else begin
					if (rep_dep < REPEAT_DEPTH) begin
						rep_stk[rep_dep] = c.after_position;
						rep_cnt[rep_dep] = c.loop_count;
						rep_dep++;
					end
					r.stop_track = (rep_dep >= REPEAT_DEPTH);
					r.next_position = c.target_address;
				end
			end
			FUNC_LOOP: begin
				if (loop_dep > 0 && loop_stk[loop_dep-1] == c.after_position) begin
					loop_cnt[loop_dep-1] = loop_cnt[loop_dep-1] - 8'd1;
					if (loop_cnt[loop_dep-1] == 0) begin
						loop_dep--;
						r.next_position = c.target_address;
					end
				end else begin
					if (loop_dep < LOOP_DEPTH) begin
						loop_stk[loop_dep] = c.after_position;
						loop_cnt[loop_dep] = c.loop_count;
						loop_dep++;
					end
					r.stop_track = (loop_dep >= LOOP_DEPTH);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void add_row(input logic [FuncW-1:0] f, input logic [PosW-1:0] t,
			input logic [PosW-1:0] a, input logic [CntW-1:0] n, input bit fx,
			input logic [PosW-1:0] nx, input bit st);
		step_row_t row;
		row.c.func = f;
		row.c.target_address = t;
		row.c.after_position = a;
		row.c.loop_count = n;
		row.fixed = fx;
		row.r.next_position = nx;
		row.r.stop_track = st;
		directed.push_back(row);
	endfunction

	// random command that mostly follows the live stack tops so loops and repeats resolve
	function automatic tfc_cmd_t random_cmd();
		tfc_cmd_t c;
		int pick;
		int aft_mode;
		pick = $urandom_range(99, 0);
		aft_mode = $urandom_range(99, 0);
		c.target_address = PosW'($urandom);
		c.after_position = (aft_mode < 85) ? PosW'($urandom) :
			(aft_mode < 90) ? 16'h0400 : (aft_mode < 95) ? 16'h0000 : 16'hFFFF;
		case ($urandom_range(19, 0))
			0:       c.loop_count = '0;
			1, 2, 3, 4, 5: c.loop_count = CntW'($urandom);
			default: c.loop_count = CntW'($urandom_range(3, 1));
		endcase
		if (pick < 8) begin
			c.func = FUNC_JUMP;
		end else if (pick < 28) begin
			c.func = FUNC_CALL;
			if (call_dep > 0 && $urandom_range(99, 0) < 30)
				c.after_position = call_stk[call_dep-1];
		end else if (pick < 46) begin
			c.func = FUNC_RETURN;
		end else if (pick < 54) begin
			c.func = FUNC_COND;
		end else if (pick < 74) begin
			c.func = FUNC_REPEAT;
			if (rep_dep > 0 && $urandom_range(99, 0) < 60)
				c.after_position = rep_stk[rep_dep-1];
		end else if (pick < 94) begin
			c.func = FUNC_LOOP;
			if (loop_dep > 0 && $urandom_range(99, 0) < 60)
				c.after_position = loop_stk[loop_dep-1];
		end else begin
			c.func = $urandom_range(1, 0) ? FUNC_RSVD_HI : FUNC_RSVD_LO;
		end
		return c;
	endfunction

	// offer one beat, wait for the handshake, then record what must come back
	task automatic send_cmd(input tfc_cmd_t c, input bit fixed, input tfc_res_t fixed_res);
		tfc_res_t r;
		while (sender_pct != 0 && $urandom_range(99, 0) < sender_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		r = flow_step(c);
		if (fixed)
			r = fixed_res;
		pending_res.push_back(r);
		n_items++;
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input bit v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		force_cond = v;
	endtask

	// receiver: random stalls plus a single long hold-off in the last phase
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= (stall_pct != 0 && $urandom_range(99, 0) < stall_pct);
		end
	end

	always @(posedge clk) begin
		tfc_res_t exp_r;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_res.size() == 0) begin
				$error("result beat with nothing expected: next_position %h stop_track %b",
					res.next_position, res.stop_track);
				fail_cnt++;
			end else begin
				exp_r = pending_res.pop_front();
				n_checked++;
				if (res.stop_track)
					n_stops++;
				if (res.next_position !== exp_r.next_position) begin
					$error("next_position mismatch: expected %h, got %h",
						exp_r.next_position, res.next_position);
					fail_cnt++;
				end
				if (res.stop_track !== exp_r.stop_track) begin
					$error("stop_track mismatch: expected %b, got %b",
						exp_r.stop_track, res.stop_track);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_cfg(1'b0);

		add_row(FUNC_RETURN, 16'h0000, 16'h1234, 8'h00, 1, 16'h1234, 1);
		add_row(FUNC_JUMP,   16'hFFFF, 16'h0000, 8'h00, 1, 16'hFFFF, 0);
		add_row(FUNC_JUMP,   16'h0000, 16'hFFFF, 8'hFF, 1, 16'h0000, 0);
		// first conditional is skipped, later ones jump
		add_row(FUNC_COND,   16'h2222, 16'h0400, 8'h00, 1, 16'h0400, 0);
		add_row(FUNC_COND,   16'h2222, 16'h0400, 8'h00, 1, 16'h2222, 0);
		add_row(FUNC_RSVD_LO, 16'h7777, 16'h0102, 8'h55, 1, 16'h0102, 0);
		add_row(FUNC_RSVD_HI, 16'h8888, 16'hFEFD, 8'hAA, 1, 16'hFEFD, 0);
		add_row(FUNC_CALL,   16'h1000, 16'h0400, 8'h00, 1, 16'h1000, 0);
		add_row(FUNC_CALL,   16'h1000, 16'h0400, 8'h00, 1, 16'h1000, 0);
		add_row(FUNC_RETURN, 16'h0000, 16'h0500, 8'h00, 1, 16'h0400, 0);
		add_row(FUNC_RETURN, 16'h0000, 16'hBEEF, 8'h00, 1, 16'hBEEF, 1);
		add_row(FUNC_REPEAT, 16'h5555, 16'hAAAA, 8'h02, 1, 16'h5555, 0);
		add_row(FUNC_REPEAT, 16'h5555, 16'hAAAA, 8'h02, 1, 16'h5555, 0);
		add_row(FUNC_REPEAT, 16'h5555, 16'hAAAA, 8'h02, 1, 16'hAAAA, 0);
		// zero count wraps to 255
		add_row(FUNC_REPEAT, 16'h0010, 16'h0020, 8'h00, 0, '0, 0);
		add_row(FUNC_REPEAT, 16'h0010, 16'h0020, 8'h00, 0, '0, 0);
		add_row(FUNC_LOOP,   16'h3000, 16'h2000, 8'h01, 1, 16'h2000, 0);
		add_row(FUNC_LOOP,   16'h3000, 16'h2000, 8'h01, 1, 16'h3000, 0);
		add_row(FUNC_LOOP,   16'h0000, 16'hFFFF, 8'hFF, 0, '0, 0);
		// fill the call stack, then issue one more call onto the full stack
		for (int k = 0; k <= CALL_DEPTH; k++)
			add_row(FUNC_CALL, PosW'(16'h4000 + k), PosW'(16'h0600 + 2 * k), 8'h00, 0, '0, 0);

		foreach (directed[i])
			send_cmd(directed[i].c, directed[i].fixed, directed[i].r);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_cfg(ph % 2 == 1);
			case (ph)
				1:       begin sender_pct = 85; stall_pct <= 0;  end
				2:       begin sender_pct = 0;  stall_pct <= 85; end
				3:       begin sender_pct = 6;  stall_pct <= 6;  end
				default: begin sender_pct = 0;  stall_pct <= 0;  end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == NUM_PHASES - 1 && i == 20)
					hold_req <= hold_req + 1;
				send_cmd(random_cmd(), 0, '0);
			end
		end
		sender_pct = 0;
		stall_pct <= 0;
		drain();

		$display("covered %0d commands over directed and %0d random phases", n_items, NUM_PHASES);
		$display("%0d results compared, %0d with stop raised, %0d mismatches",
			n_checked, n_stops, fail_cnt);
		if (fail_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
